@@ hw/rtl/route_record_stream_parser_assert.svh @@
// ----------------------------------------------------------------------------
// route record stream parser assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef ROUTE_RECORD_STREAM_PARSER_ASSERT_SVH
`define ROUTE_RECORD_STREAM_PARSER_ASSERT_SVH

// same-cycle implication
`define RRSP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrsp assertion failed");

// next-cycle implication
`define RRSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrsp assertion failed");

`endif

@@ hw/rtl/rrsp_pkg.sv @@
// ----------------------------------------------------------------------------
// rrsp_pkg
// types and constants shared by the route record stream parser
// ----------------------------------------------------------------------------
package rrsp_pkg;

   localparam int unsigned NumberWidth = 32;
   localparam int unsigned RouteWidth  = 31;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned KindWidth   = 3;

   localparam logic [ByteWidth-1:0] NulByte   = 8'd0;
   localparam logic [ByteWidth-1:0] CtrlLimit = 8'd31;

   localparam logic ActionData = 1'b0;
   localparam logic ActionEos  = 1'b1;

   typedef enum logic [3:0] {
      PhNumber = 4'b0001,
      PhStart  = 4'b0010,
      PhEnd    = 4'b0100,
      PhError  = 4'b1000
   } phase_type;

   typedef enum logic [KindWidth-1:0] {
      KNumDone    = 3'd0,
      KStartByte  = 3'd1,
      KEndByte    = 3'd2,
      KRecordDone = 3'd3,
      KBadNumber  = 3'd4,
      KControl    = 3'd5,
      KTruncated  = 3'd6,
      KCleanEnd   = 3'd7
   } kind_type;

   typedef struct packed {
      logic                 action;
      logic [ByteWidth-1:0] data_byte;
   } item_type;

   typedef struct packed {
      kind_type              kind;
      logic [RouteWidth-1:0] route_number;
      logic [ByteWidth-1:0]  text_byte;
   } result_type;

endpackage

@@ hw/rtl/rrsp_channels.sv @@
// ----------------------------------------------------------------------------
// rrsp channel interfaces
// valid/ready channels for input beats and result beats
// ----------------------------------------------------------------------------
interface rrsp_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [rrsp_pkg::ByteWidth-1:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface rrsp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rrsp_pkg::KindWidth-1:0]  kind;
   logic [rrsp_pkg::RouteWidth-1:0] route_number;
   logic [rrsp_pkg::ByteWidth-1:0]  text_byte;

   modport source (output valid, output kind, output route_number, output text_byte,
                   input ready);
   modport sink (input valid, input kind, input route_number, input text_byte,
                 output ready);
endinterface

@@ hw/rtl/route_record_stream_parser.sv @@
// ----------------------------------------------------------------------------
// route_record_stream_parser
// byte-serial parser for route records: number, start text, end text
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle, sustained, as long as the response
// side keeps ready high: a beat passes from the input register through one
// level of phase and classification logic into the result register, which
// drives the response channel. A beat that gives no result (a partial number
// byte, the terminator of the start field, a byte in the error phase) still
// needs a free result slot to move on. The result register's ready feeds
// combinationally back to req ready, so the input register and result
// register together hold at most one beat each and nothing is lost under
// back-pressure. Each record is a four-byte little-endian number followed by
// two NUL-terminated text fields; a number of zero or with the sign bit set,
// or a text byte from 1 to 31, reports an error and silences the block until
// the end-of-stream beat.
// ----------------------------------------------------------------------------
module route_record_stream_parser (
   input  logic       clock,
   input  logic       reset,
   rrsp_req_if.sink   req_bus,
   rrsp_rsp_if.source rsp_bus
);

   // input register towards parser
   logic                 item_valid;
   rrsp_pkg::item_type   item;

   // parser towards result register
   logic                 has_result;
   rrsp_pkg::result_type result;

   // handshake between the stages
   logic                 can_take;
   logic                 step;
   logic                 load;

   // a held beat is consumed once the result slot is free or draining
   assign step = item_valid && can_take;
   assign load = step && has_result;

   rrsp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .step       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   rrsp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (item),
      .has_result (has_result),
      .result     (result)
   );

   rrsp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .rsp_bus  (rsp_bus),
      .load     (load),
      .result   (result),
      .can_take (can_take)
   );

endmodule

@@ hw/rtl/rrsp_in_stage.sv @@
// ----------------------------------------------------------------------------
// rrsp_in_stage
// input register: holds one beat until the parser consumes it
// ----------------------------------------------------------------------------
module rrsp_in_stage (
   input  logic               clock,
   input  logic               reset,
   rrsp_req_if.sink           req_bus,
   input  logic               step,
   output logic               item_valid,
   output rrsp_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   rrsp_pkg::item_type item_ff;
   logic               take;

   // free slot, or the held beat leaves this cycle
   assign req_bus.ready = !valid_ff || step;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.action    <= req_bus.action;
         item_ff.data_byte <= req_bus.data_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ hw/rtl/rrsp_parser.sv @@
// ----------------------------------------------------------------------------
// rrsp_parser
// record phase tracking, number assembly and text byte classification
// ----------------------------------------------------------------------------
`include "route_record_stream_parser_assert.svh"

module rrsp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  rrsp_pkg::item_type   item,
   output logic                 has_result,
   output rrsp_pkg::result_type result
);

   rrsp_pkg::phase_type                   phase_ff;
   rrsp_pkg::phase_type                   phase_in;
   logic [1:0]                            count_ff;
   logic [1:0]                            count_in;
   logic [rrsp_pkg::NumberWidth-1:0]      acc_ff;
   logic [rrsp_pkg::NumberWidth-1:0]      acc_in;
   logic [rrsp_pkg::ByteWidth-1:0]        b;
   logic                                  is_control;

   assign b          = item.data_byte;
   assign is_control = (b != rrsp_pkg::NulByte) && (b <= rrsp_pkg::CtrlLimit);

   always_comb begin
      phase_in            = phase_ff;
      count_in            = count_ff;
      acc_in              = acc_ff;
      has_result          = 1'b0;
      result.kind         = rrsp_pkg::KCleanEnd;
      result.route_number = '0;
      result.text_byte    = '0;

      if (item.action == rrsp_pkg::ActionEos) begin
         phase_in = rrsp_pkg::PhNumber;
         count_in = 2'd0;
         acc_in   = '0;
         unique case (phase_ff)
            rrsp_pkg::PhNumber: begin
               has_result  = 1'b1;
               result.kind = rrsp_pkg::KCleanEnd;
            end
            rrsp_pkg::PhStart, rrsp_pkg::PhEnd: begin
               has_result  = 1'b1;
               result.kind = rrsp_pkg::KTruncated;
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
      end else begin
         unique case (phase_ff)
            rrsp_pkg::PhNumber: begin
               // bytes enter at the top, first byte ends in the low lane
               acc_in   = {b, acc_ff[rrsp_pkg::NumberWidth-1:rrsp_pkg::ByteWidth]};
               count_in = count_ff + 2'd1;
               if (count_ff == 2'd3) begin
                  has_result = 1'b1;
                  if (acc_in == '0 || acc_in[rrsp_pkg::NumberWidth-1]) begin
                     phase_in    = rrsp_pkg::PhError;
                     result.kind = rrsp_pkg::KBadNumber;
                  end else begin
                     phase_in            = rrsp_pkg::PhStart;
                     result.kind         = rrsp_pkg::KNumDone;
                     result.route_number = acc_in[rrsp_pkg::RouteWidth-1:0];
                  end
               end
            end
            rrsp_pkg::PhStart, rrsp_pkg::PhEnd: begin
               if (b == rrsp_pkg::NulByte) begin
                  if (phase_ff == rrsp_pkg::PhStart) begin
                     phase_in = rrsp_pkg::PhEnd;
                  end else begin
                     phase_in            = rrsp_pkg::PhNumber;
                     count_in            = 2'd0;
                     has_result          = 1'b1;
                     result.kind         = rrsp_pkg::KRecordDone;
                     result.route_number = acc_ff[rrsp_pkg::RouteWidth-1:0];
                  end
               end else if (is_control) begin
                  phase_in    = rrsp_pkg::PhError;
                  has_result  = 1'b1;
                  result.kind = rrsp_pkg::KControl;
               end else begin
                  has_result       = 1'b1;
                  result.text_byte = b;
                  result.kind      = (phase_ff == rrsp_pkg::PhStart) ?
                                     rrsp_pkg::KStartByte : rrsp_pkg::KEndByte;
               end
            end
            default: begin
               // error phase: data bytes are dropped
               has_result = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rrsp_pkg::PhNumber;
         count_ff <= 2'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         acc_ff <= acc_in;
      end
   end

   `RRSP_ASSERT_SAME(a_count_only_in_number, clock, reset,
      count_ff != 2'd0, phase_ff == rrsp_pkg::PhNumber)
   `RRSP_ASSERT_NEXT(a_eos_restarts, clock, reset,
      step && item.action == rrsp_pkg::ActionEos,
      phase_ff == rrsp_pkg::PhNumber && count_ff == 2'd0)
   `RRSP_ASSERT_SAME(a_error_silent, clock, reset,
      phase_ff == rrsp_pkg::PhError && item.action == rrsp_pkg::ActionData,
      !has_result)
   `RRSP_ASSERT_SAME(a_record_from_end, clock, reset,
      has_result && result.kind == rrsp_pkg::KRecordDone, phase_ff == rrsp_pkg::PhEnd)

endmodule

@@ hw/rtl/rrsp_out_stage.sv @@
// ----------------------------------------------------------------------------
// rrsp_out_stage
// result register driving the response channel
// ----------------------------------------------------------------------------
module rrsp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   rrsp_rsp_if.source           rsp_bus,
   input  logic                 load,
   input  rrsp_pkg::result_type result,
   output logic                 can_take
);

   logic                 valid_ff;
   logic                 valid_in;
   rrsp_pkg::result_type result_ff;

   assign can_take = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.kind         = result_ff.kind;
   assign rsp_bus.route_number = result_ff.route_number;
   assign rsp_bus.text_byte    = result_ff.text_byte;

endmodule
